FILE: hw/rtl/x86bd_pkg.sv
// Shared types, constants and opcode codes for the x86 subset byte decoder.
package x86bd_pkg;

  // Width of the running byte offset; it saturates at its all-ones value.
  localparam int OFFSET_BITS = 16;
  localparam int LEN_BITS    = 16;
  localparam int START_BITS  = 16;
  // Compare width: large enough for offset or length plus a small increment.
  localparam int CMP_BITS    = ((OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS) + 4;

  localparam int OUT_BITS    = 4 + 3 + 8 + 3 + START_BITS;
  localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;
  localparam int TDATA_BITS  = OUT_BYTES * 8;

  // Opcode bytes
  localparam logic [7:0] BYTE_NOP     = 8'h90;
  localparam logic [7:0] BYTE_RET     = 8'hC3;
  localparam logic [7:0] BYTE_ESC     = 8'h0F;
  localparam logic [7:0] BYTE_SYSCALL = 8'h05;
  localparam logic [7:0] BYTE_STORE   = 8'h89;
  localparam logic [7:0] BYTE_LOAD    = 8'h8B;
  localparam logic [7:0] BYTE_ADD     = 8'h01;
  localparam logic [7:0] BYTE_SUB     = 8'h29;
  localparam logic [7:0] BYTE_AND     = 8'h21;
  localparam logic [7:0] BYTE_OR      = 8'h09;
  localparam logic [7:0] BYTE_XOR     = 8'h31;
  localparam logic [7:0] IMM_MARK     = 8'd255;

  // Immediate and displacement lengths
  localparam logic [3:0] SKIP_IMM  = 4'd8;
  localparam logic [3:0] SKIP_D8   = 4'd1;
  localparam logic [3:0] SKIP_D32  = 4'd4;

  // ModRM mod field codes
  localparam logic [1:0] MOD_D8  = 2'd1;
  localparam logic [1:0] MOD_D32 = 2'd2;
  localparam logic [1:0] MOD_REG = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_RET     = 4'd1,
    OP_SYSCALL = 4'd2,
    OP_PUSH    = 4'd3,
    OP_POP     = 4'd4,
    OP_MOVE    = 4'd5,
    OP_STORE   = 4'd6,
    OP_LOAD    = 4'd7,
    OP_ADD     = 4'd8,
    OP_SUB     = 4'd9,
    OP_AND     = 4'd10,
    OP_OR      = 4'd11,
    OP_XOR     = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_SECOND = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [OFFSET_BITS-1:0] byte_offset;
    phase_t                 phase;
    logic [3:0]             skip_left;
    logic [7:0]             held_opcode;
    logic [START_BITS-1:0]  held_start;
  } dec_state_t;

  // One decoded instruction
  typedef struct packed {
    logic                  emit;
    op_t                   op;
    logic [2:0]            dest_reg;
    logic [7:0]            src_one;
    logic [2:0]            src_two;
    logic [START_BITS-1:0] start_offset;
  } dec_result_t;

endpackage

FILE: hw/rtl/x86_subset_byte_decoder_top.sv
// Top level of the x86 subset byte decoder: stream ports, state and result registers.
//
// Decodes a stream of machine-code bytes, one byte per item, into at most one
// intermediate instruction per byte. A byte is taken every cycle the result
// register is empty or being drained; its instruction, if any, is registered
// and appears on the output in the next cycle. The single result register
// sets the rate: one byte per clock with no stall on the output side.
// code_length must be written while no bytes are in flight; a byte with the
// restart flag begins a new block at offset zero.
module x86_subset_byte_decoder_top
  import x86bd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [LEN_BITS-1:0]   cfg_wdata,     // code_length
  // byte input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,       // [7:0] code_byte
  input  logic                  s_tuser,       // [0] restart
  // instruction output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata        // op, dest_reg, src_one, src_two,
                                               // start_offset, zero fill
);

  dec_state_t          state;
  dec_state_t          state_next;
  dec_result_t         result;
  logic [LEN_BITS-1:0] code_length;
  logic                accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  x86bd_step u_step (
    .state       (state),
    .code_byte   (s_tdata),
    .restart     (s_tuser),
    .code_length (code_length),
    .state_next  (state_next),
    .result      (result)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= '0;
    end else if (cfg_we) begin
      code_length <= cfg_wdata;
    end
  end

  // Decoder state; all zeros is offset zero, expecting an opcode
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && result.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.emit) begin
      m_tdata <= TDATA_BITS'({result.start_offset, result.src_two, result.src_one,
                              result.dest_reg, result.op});
    end
  end

endmodule

FILE: hw/rtl/x86bd_step.sv
// Per-byte decode step: next decoder state and the instruction this byte completes.
module x86bd_step
  import x86bd_pkg::*;
(
  input  dec_state_t        state,
  input  logic [7:0]        code_byte,
  input  logic              restart,
  input  logic [LEN_BITS-1:0] code_length,
  output dec_state_t        state_next,
  output dec_result_t       result
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [OFFSET_BITS-1:0] off;
  logic [CMP_BITS-1:0]    off_w;
  logic [CMP_BITS-1:0]    len_w;
  logic [START_BITS-1:0]  start;
  logic [1:0]             modrm_mod;
  logic [2:0]             modrm_reg;
  logic [2:0]             modrm_rm;
  logic                   past_end;
  logic                   imm_fits;
  logic                   second_fits;
  logic                   is_arith;
  op_t                    arith_op;

  // Offset of this byte, after an optional restart
  assign off      = restart ? '0 : state.byte_offset;
  assign off_w    = CMP_BITS'(off);
  assign len_w    = CMP_BITS'(code_length);
  assign start    = START_BITS'(off);
  assign past_end = (off_w >= len_w);
  assign imm_fits    = ((off_w + CMP_BITS'(9)) <= len_w);
  assign second_fits = ((off_w + CMP_BITS'(1)) < len_w);

  assign modrm_mod = code_byte[7:6];
  assign modrm_reg = code_byte[5:3];
  assign modrm_rm  = code_byte[2:0];

  // Arithmetic opcode classification, on the held byte
  always_comb begin
    is_arith = 1'b1;
    arith_op = OP_XOR;
    case (state.held_opcode)
      BYTE_ADD: arith_op = OP_ADD;
      BYTE_SUB: arith_op = OP_SUB;
      BYTE_AND: arith_op = OP_AND;
      BYTE_OR:  arith_op = OP_OR;
      BYTE_XOR: arith_op = OP_XOR;
      default:  is_arith = 1'b0;
    endcase
  end

  // Phase handling
  always_comb begin
    state_next             = state;
    state_next.byte_offset = (off == OFF_MAX) ? off : off + OFFSET_BITS'(1);
    if (restart) begin
      state_next.skip_left = '0;
    end
    result              = '0;
    result.op           = OP_NOP;
    result.start_offset = start;

    if (past_end) begin
      state_next.phase     = PH_OPCODE;
      state_next.skip_left = '0;
    end else if (!restart && state.phase == PH_SKIP) begin
      // Skipping immediate or displacement bytes
      if (state.skip_left <= 4'd1) begin
        state_next.skip_left = '0;
        state_next.phase     = PH_OPCODE;
      end else begin
        state_next.skip_left = state.skip_left - 4'd1;
      end
    end else if (!restart && state.phase == PH_SECOND) begin
      // Second byte of a two-byte form
      result.emit         = 1'b1;
      result.start_offset = state.held_start;
      state_next.phase    = PH_OPCODE;
      if (state.held_opcode == BYTE_ESC) begin
        result.op = (code_byte == BYTE_SYSCALL) ? OP_SYSCALL : OP_NOP;
      end else if (state.held_opcode == BYTE_STORE || state.held_opcode == BYTE_LOAD) begin
        if (modrm_mod == MOD_D8) begin
          state_next.skip_left = SKIP_D8;
          state_next.phase     = PH_SKIP;
        end else if (modrm_mod == MOD_D32) begin
          state_next.skip_left = SKIP_D32;
          state_next.phase     = PH_SKIP;
        end
        if (state.held_opcode == BYTE_STORE) begin
          result.op       = OP_STORE;
          result.dest_reg = modrm_rm;
          result.src_one  = {5'd0, modrm_reg};
        end else begin
          result.op       = OP_LOAD;
          result.dest_reg = modrm_reg;
          result.src_one  = {5'd0, modrm_rm};
        end
      end else if (is_arith && modrm_mod == MOD_REG) begin
        result.op       = arith_op;
        result.dest_reg = modrm_reg;
        result.src_one  = {5'd0, modrm_reg};
        result.src_two  = modrm_rm;
      end
    end else begin
      // Expecting an opcode (the unused phase code lands here too)
      state_next.phase = PH_OPCODE;
      result.emit      = 1'b1;
      if (code_byte == BYTE_RET) begin
        result.op = OP_RET;
      end else if (code_byte[7:3] == 5'b01010) begin
        result.op      = OP_PUSH;
        result.src_one = {5'd0, code_byte[2:0]};
      end else if (code_byte[7:3] == 5'b01011) begin
        result.op       = OP_POP;
        result.dest_reg = code_byte[2:0];
      end else if (code_byte[7:3] == 5'b10111) begin
        if (imm_fits) begin
          state_next.skip_left = SKIP_IMM;
          state_next.phase     = PH_SKIP;
          result.op            = OP_MOVE;
          result.dest_reg      = code_byte[2:0];
          result.src_one       = IMM_MARK;
        end
      end else if (code_byte == BYTE_ESC || code_byte == BYTE_STORE ||
                   code_byte == BYTE_LOAD || code_byte == BYTE_ADD ||
                   code_byte == BYTE_SUB || code_byte == BYTE_AND ||
                   code_byte == BYTE_OR || code_byte == BYTE_XOR) begin
        if (second_fits) begin
          state_next.held_opcode = code_byte;
          state_next.held_start  = start;
          state_next.phase       = PH_SECOND;
          result.emit            = 1'b0;
        end
      end
    end
  end

endmodule

FILE: dv/x86bd_stream_checker.sv
// Stream checker for the x86 subset byte decoder: predicts instructions and compares them.
`timescale 1ns / 100ps

module x86bd_stream_checker
  import x86bd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LEN_BITS-1:0]   cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [TDATA_BITS-1:0] m_tdata,
  output int                    fail_count,
  output int                    pending_count,
  output int                    insn_count,
  output logic [15:0]           ops_seen
);

  typedef struct {
    op_t                   op;
    logic [2:0]            dest;
    logic [7:0]            src_a;
    logic [2:0]            src_b;
    logic [START_BITS-1:0] start;
  } insn_t;

  localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;

  // Decoder state as seen from outside
  logic [LEN_BITS-1:0]    code_len;
  logic [OFFSET_BITS-1:0] cur_offset;
  phase_t                 cur_phase;
  logic [3:0]             skip_cnt;
  logic [7:0]             held_byte;
  logic [START_BITS-1:0]  held_at;

  insn_t      expected_insns[$];
  int         n_errors;
  int         n_checked;
  logic [15:0] seen;

  function automatic bit is_arith(input logic [7:0] b);
    return b == BYTE_ADD || b == BYTE_SUB || b == BYTE_AND || b == BYTE_OR || b == BYTE_XOR;
  endfunction

  function automatic op_t arith_code(input logic [7:0] b);
    case (b)
      BYTE_ADD: return OP_ADD;
      BYTE_SUB: return OP_SUB;
      BYTE_AND: return OP_AND;
      BYTE_OR:  return OP_OR;
      default:  return OP_XOR;
    endcase
  endfunction

  task automatic push_insn(input op_t op, input logic [2:0] dest, input logic [7:0] src_a,
                           input logic [2:0] src_b, input logic [START_BITS-1:0] start);
    insn_t e;
    e.op    = op;
    e.dest  = dest;
    e.src_a = src_a;
    e.src_b = src_b;
    e.start = start;
    expected_insns.push_back(e);
  endtask

  // Advance the decoder by one code byte, queueing the instruction it completes
  task automatic decode_byte(input logic [7:0] b, input logic restart);
    logic [OFFSET_BITS-1:0] off;
    int unsigned            offw;
    int unsigned            len;
    logic [1:0]             md;
    logic [2:0]             rg;
    logic [2:0]             rm;
    if (restart) begin
      cur_offset = '0;
      cur_phase  = PH_OPCODE;
      skip_cnt   = '0;
    end
    off  = cur_offset;
    offw = off;
    len  = code_len;
    if (cur_offset != OFFSET_TOP) cur_offset = cur_offset + 1'b1;

    // past the configured length: nothing, and decoding starts over
    if (offw >= len) begin
      cur_phase = PH_OPCODE;
      skip_cnt  = '0;
      return;
    end

    md = b[7:6];
    rg = b[5:3];
    rm = b[2:0];
    case (cur_phase)
      PH_SKIP: begin
        if (skip_cnt != 0) skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == 0) cur_phase = PH_OPCODE;
      end
      PH_SECOND: begin
        cur_phase = PH_OPCODE;
        if (held_byte == BYTE_ESC) begin
          push_insn((b == BYTE_SYSCALL) ? OP_SYSCALL : OP_NOP, 3'd0, 8'd0, 3'd0, held_at);
        end else if (held_byte == BYTE_STORE || held_byte == BYTE_LOAD) begin
          if (md == MOD_D8) begin
            skip_cnt  = SKIP_D8;
            cur_phase = PH_SKIP;
          end else if (md == MOD_D32) begin
            skip_cnt  = SKIP_D32;
            cur_phase = PH_SKIP;
          end
          if (held_byte == BYTE_STORE) push_insn(OP_STORE, rm, {5'd0, rg}, 3'd0, held_at);
          else push_insn(OP_LOAD, rg, {5'd0, rm}, 3'd0, held_at);
        end else if (is_arith(held_byte) && md == MOD_REG) begin
          push_insn(arith_code(held_byte), rg, {5'd0, rg}, rm, held_at);
        end else begin
          push_insn(OP_NOP, 3'd0, 8'd0, 3'd0, held_at);
        end
      end
      default: begin
        // opcode byte; the unused phase code lands here too
        cur_phase = PH_OPCODE;
        if (b == BYTE_NOP) begin
          push_insn(OP_NOP, 3'd0, 8'd0, 3'd0, off);
        end else if (b == BYTE_RET) begin
          push_insn(OP_RET, 3'd0, 8'd0, 3'd0, off);
        end else if (b[7:3] == 5'b01010) begin
          push_insn(OP_PUSH, 3'd0, {5'd0, rm}, 3'd0, off);
        end else if (b[7:3] == 5'b01011) begin
          push_insn(OP_POP, rm, 8'd0, 3'd0, off);
        end else if (b[7:3] == 5'b10111) begin
          // mov r,imm needs all eight immediate bytes inside the block
          if (offw + 9 <= len) begin
            skip_cnt  = SKIP_IMM;
            cur_phase = PH_SKIP;
            push_insn(OP_MOVE, rm, IMM_MARK, 3'd0, off);
          end else begin
            push_insn(OP_NOP, 3'd0, 8'd0, 3'd0, off);
          end
        end else if (b == BYTE_ESC || b == BYTE_STORE || b == BYTE_LOAD || is_arith(b)) begin
          if (offw + 1 < len) begin
            held_byte = b;
            held_at   = off;
            cur_phase = PH_SECOND;
          end else begin
            push_insn(OP_NOP, 3'd0, 8'd0, 3'd0, off);
          end
        end else begin
          push_insn(OP_NOP, 3'd0, 8'd0, 3'd0, off);
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Compare accepted instructions first, then fold in the accepted byte
  always @(posedge clk) begin
    insn_t want;
    insn_t got;
    logic [TDATA_BITS-OUT_BITS-1:0] fill;
    if (rst) begin
      code_len   = '0;
      cur_offset = '0;
      cur_phase  = PH_OPCODE;
      skip_cnt   = '0;
      held_byte  = '0;
      held_at    = '0;
      expected_insns.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.op    = op_t'(m_tdata[3:0]);
        got.dest  = m_tdata[6:4];
        got.src_a = m_tdata[14:7];
        got.src_b = m_tdata[17:15];
        got.start = m_tdata[33:18];
        fill      = m_tdata[TDATA_BITS-1:OUT_BITS];
        n_checked++;
        if (expected_insns.size() == 0) begin
          n_errors++;
          $display("[%0t] unexpected item: expected none, actual op %0d dest %0d src %0d/%0d at %0d",
                   $time, got.op, got.dest, got.src_a, got.src_b, got.start);
        end else begin
          want = expected_insns.pop_front();
          seen[want.op] = 1'b1;
          check_field("op", want.op, got.op);
          check_field("dest_reg", want.dest, got.dest);
          check_field("src_one", want.src_a, got.src_a);
          check_field("src_two", want.src_b, got.src_b);
          check_field("start_offset", want.start, got.start);
          check_field("zero fill", 0, fill);
        end
      end
      if (cfg_we) code_len = cfg_wdata;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
    end
    fail_count    <= n_errors;
    pending_count <= expected_insns.size();
    insn_count    <= n_checked;
    ops_seen      <= seen;
  end

  initial begin
    n_errors  = 0;
    n_checked = 0;
    seen      = '0;
  end

endmodule

FILE: dv/tb_x86_subset_byte_decoder_top.sv
// Testbench top for the x86 subset byte decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_x86_subset_byte_decoder_top;
  import x86bd_pkg::*;

  localparam int          RAND_ITEMS  = 1200;
  localparam int unsigned BURST_BYTES = 100;
  localparam logic [7:0]  BYTE_PUSH0  = 8'h50;
  localparam logic [7:0]  BYTE_POP7   = 8'h5F;
  localparam logic [7:0]  BYTE_MOVI0  = 8'hB8;
  localparam logic [7:0]  BYTE_MOVI7  = 8'hBF;
  localparam logic [7:0]  BYTE_UNDEF  = 8'hFF;
  localparam logic [7:0]  ARITH_BYTES [5] = '{BYTE_ADD, BYTE_SUB, BYTE_AND, BYTE_OR, BYTE_XOR};

  // Opening sequence at length 24: every op but move and store, a bad second byte,
  // memory arith, short immediate, prefix as last valid byte, and one byte past the end
  localparam logic [7:0] OPENING [25] = '{
    BYTE_NOP, BYTE_RET, BYTE_ESC, BYTE_SYSCALL, BYTE_ESC, BYTE_UNDEF,
    BYTE_PUSH0, BYTE_POP7, BYTE_ADD, 8'hC1, BYTE_SUB, 8'hD8, BYTE_AND, 8'hC0,
    BYTE_OR, 8'hF7, BYTE_XOR, 8'h00, BYTE_LOAD, 8'h45, 8'hAA, BYTE_UNDEF,
    BYTE_MOVI7, BYTE_ESC, BYTE_NOP
  };

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [LEN_BITS-1:0]   cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;     // [7:0] code_byte
  logic                  s_tuser   = 1'b0;   // [0] restart
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;            // op, dest_reg, src_one, src_two, start_offset

  int          fail_count;
  int          pending;
  int          insn_count;
  logic [15:0] ops_seen;

  // Stimulus bookkeeping
  int unsigned cur_len     = 0;
  int unsigned blk_pos     = 0;
  int unsigned counted     = 0;
  int unsigned bytes_sent  = 0;
  int unsigned n_settings  = 0;
  bit          restart_next = 1'b0;
  bit          quiet        = 1'b0;
  bit          noise        = 1'b0;

  x86_subset_byte_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  x86bd_stream_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending),
    .insn_count    (insn_count),
    .ops_seen      (ops_seen)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Drive one byte and hold it until accepted, then maybe idle
  task automatic send_byte(input logic [7:0] b);
    int unsigned g;
    logic        rs;
    rs = restart_next || (noise && $urandom_range(0, 199) == 0);
    restart_next = 1'b0;
    if (rs) blk_pos = 0;
    if (blk_pos < cur_len) counted++;
    blk_pos++;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= rs;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    g = quiet ? 0 : gap_len();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Let the block drain, then write code_length
  task automatic set_length(input int unsigned len);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len[LEN_BITS-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_len = len;
    n_settings++;
  endtask

  // One well-formed instruction with random operands, or a stray byte
  task automatic send_insn();
    logic [7:0] mrm;
    case ($urandom_range(0, 11))
      0: send_byte(BYTE_NOP);
      1: send_byte(BYTE_RET);
      2: begin
        send_byte(BYTE_ESC);
        send_byte(BYTE_SYSCALL);
      end
      3: begin
        send_byte(BYTE_ESC);
        send_byte(8'($urandom));
      end
      4: send_byte(8'($urandom_range(BYTE_PUSH0, BYTE_PUSH0 + 7)));
      5: send_byte(8'($urandom_range(BYTE_POP7 - 7, BYTE_POP7)));
      6: begin
        send_byte(8'($urandom_range(BYTE_MOVI0, BYTE_MOVI7)));
        repeat (8) send_byte(8'($urandom));
      end
      7, 8: begin
        send_byte($urandom_range(0, 1) ? BYTE_STORE : BYTE_LOAD);
        mrm = 8'($urandom);
        send_byte(mrm);
        if (mrm[7:6] == MOD_D8) repeat (SKIP_D8) send_byte(8'($urandom));
        else if (mrm[7:6] == MOD_D32) repeat (SKIP_D32) send_byte(8'($urandom));
      end
      9, 10: begin
        send_byte(ARITH_BYTES[$urandom_range(0, 4)]);
        if ($urandom_range(0, 4) == 0) mrm = 8'($urandom);
        else mrm = {MOD_REG, 6'($urandom)};
        send_byte(mrm);
      end
      default: send_byte(8'($urandom));
    endcase
  endtask

  // Output side flow control
  initial begin
    int unsigned g;
    @(posedge clk);
    forever begin
      if (quiet) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        g = gap_len();
        if (g != 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned span;
    int unsigned sent0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening
    set_length(24);
    restart_next = 1'b1;
    foreach (OPENING[i]) send_byte(OPENING[i]);

    // zero length: everything ignored
    set_length(0);
    restart_next = 1'b1;
    repeat (4) send_byte(8'($urandom));

    // full length, one unbroken burst without idling
    set_length(16'hFFFF);
    quiet = 1'b1;
    restart_next = 1'b1;
    repeat (BURST_BYTES) send_byte(8'($urandom));
    quiet = 1'b0;

    // random blocks of instructions under a range of lengths
    noise   = 1'b1;
    counted = 0;
    while (counted < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65) len = $urandom_range(1, 40);
      else if (r < 80) len = $urandom_range(41, 300);
      else if (r < 92) begin
        case ($urandom_range(0, 3))
          0: len = 1;
          1: len = 2;
          2: len = 9;
          default: len = 10;
        endcase
      end else len = $urandom_range(301, 65535);
      set_length(len);
      repeat ($urandom_range(1, 4)) begin
        if (len > 120) span = $urandom_range(20, 120);
        else span = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        restart_next = ($urandom_range(0, 9) != 0);
        sent0 = bytes_sent;
        while (bytes_sent - sent0 < span) send_insn();
      end
    end

    // drain and settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Summary: %0d bytes driven over %0d length settings, %0d instructions checked",
             bytes_sent, n_settings, insn_count);
    $display("Summary: %0d of 13 instruction kinds seen, one gapless burst at full length",
             $countones(ops_seen));
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12000000;
    $display("Verification failed");
    $finish;
  end

endmodule
